// ===== hw/rtl/fnds_pkg.sv =====
// Shared constants, types and state codes for the non-dominated sort block.
package fnds_pkg;

  localparam int unsigned MAX_POINTS     = 64;
  localparam int unsigned MAX_OBJECTIVES = 8;
  localparam int unsigned PT_W   = $clog2(MAX_POINTS);
  localparam int unsigned OBJ_W  = $clog2(MAX_OBJECTIVES);
  localparam int unsigned CNT_W  = PT_W + 1;
  localparam int unsigned RANK_W = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned OBJ_DEPTH = MAX_POINTS * MAX_OBJECTIVES;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CMP,
    ST_RANK,
    ST_NEXT,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_HOLD
  } state_e;

  // Tag that travels with one objective pair through the compare stage.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic self;
  } cmp_ctl_t;

endpackage

// ===== hw/rtl/fnds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fnds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/fnds_cmp.sv =====
// Objective-by-objective domination test of one point pair.
module fnds_cmp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fnds_pkg::cmp_ctl_t                ctl_i,
  input  logic signed [fnds_pkg::VAL_W-1:0] a_i,
  input  logic signed [fnds_pkg::VAL_W-1:0] b_i,
  output logic                              dom_o
);

  logic worse_q, worse_d, better_q, better_d;

  // fold this objective into the running flags
  always_comb begin
    worse_d  = (ctl_i.first ? 1'b0 : worse_q)  | (a_i > b_i);
    better_d = (ctl_i.first ? 1'b0 : better_q) | (a_i < b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worse_q  <= 1'b0;
      better_q <= 1'b0;
    end else if (ctl_i.valid) begin
      worse_q  <= worse_d;
      better_q <= better_d;
    end
  end

  assign dom_o = ctl_i.valid & ctl_i.last & ~ctl_i.self & ~worse_d & better_d;

endmodule

// ===== hw/rtl/fast_non_dominated_sort.sv =====
// Top level of the Pareto front ranking block.
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one word per objective value,
//    num_objectives words per point, last_in_set_i on the final word of a set.
//  - Config channel (cfg_valid_i / cfg_ready_o): writes num_objectives; ready
//    is always high. Values 0 act as 1, values above 8 act as 8.
//  - Output channel (out_valid_o / out_stall_i): one word per complete point
//    in load order with its front rank; last_result_o marks the final word.
// Sequence: after the last word, the compare pass reads one objective pair
// per cycle out of two copies of the objective memory and drains the pipe,
// then each front round reads the domination column memory, for up to N+1
// rounds. Each result is then read from the rank memory and held until it is
// taken. The input stalls from the last word until the final result is taken,
// so one set is in the block at a time.
// Reset: control state clears, num_objectives returns to 2; memory contents
// need no clearing since every entry read is first written in the same set.
// A receiver stall holds the output word and the block until it drops.
// Points beyond 64 are dropped and set overflow_o on every result of the set.
module fast_non_dominated_sort (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fnds_pkg::VAL_W-1:0]   objective_value_i,
  input  logic                                last_in_set_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fnds_pkg::CFG_W-1:0]          num_objectives_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [fnds_pkg::PT_W-1:0]           point_index_o,
  output logic [fnds_pkg::RANK_W-1:0]         front_rank_o,
  output logic                                last_result_o,
  output logic                                overflow_o
);

  localparam int unsigned PW = fnds_pkg::PT_W;
  localparam int unsigned OW = fnds_pkg::OBJ_W;
  localparam int unsigned CW = fnds_pkg::CNT_W;
  localparam int unsigned RW = fnds_pkg::RANK_W;
  localparam int unsigned NP = fnds_pkg::MAX_POINTS;

  fnds_pkg::state_e state_q, state_d;

  logic [fnds_pkg::CFG_W-1:0] cfg_q;
  logic [OW-1:0] mlast_q;            // effective objective count minus one
  logic [CW-1:0] pc_q;               // complete points loaded
  logic [OW-1:0] oc_q;               // objective within the current point
  logic          ovf_q;

  logic [PW-1:0] i_q, j_q;
  logic [OW-1:0] k_q;
  logic          issue_done_q;
  fnds_pkg::cmp_ctl_t ctl_q;
  logic          ilast_q;
  logic [PW-1:0] ti_q, tj_q;
  logic [NP-1:0] col_q;

  logic [NP-1:0] ranked_q, front_q;
  logic [RW-1:0] round_q;
  logic          rv_q;
  logic [PW-1:0] rj_q;

  logic [PW-1:0] p_q;

  // memory controls
  logic                    obj_we, obj_re;
  logic [PW+OW-1:0]        obj_waddr, obj_raddr_a, obj_raddr_b;
  logic [fnds_pkg::VAL_W-1:0] obj_a, obj_b;
  logic                    col_we, col_re;
  logic [NP-1:0]           col_wdata, col_rdata;
  logic                    rank_we, rank_re;
  logic [RW-1:0]           rank_rdata;

  logic          in_acc, dom, hit, issue_last;
  logic [OW-1:0] mlast_cfg;
  logic          pt_done;
  logic [CW-1:0] pc_next;
  logic [PW-1:0] n_last;

  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign n_last      = PW'(pc_q - CW'(1));

  // clamp the register to 1..MAX_OBJECTIVES, held as count minus one
  always_comb begin
    if (cfg_q == '0) begin
      mlast_cfg = '0;
    end else if (cfg_q > fnds_pkg::CFG_W'(fnds_pkg::MAX_OBJECTIVES)) begin
      mlast_cfg = OW'(fnds_pkg::MAX_OBJECTIVES - 1);
    end else begin
      mlast_cfg = OW'(cfg_q - fnds_pkg::CFG_W'(1));
    end
  end

  assign pt_done = (oc_q >= mlast_cfg);
  assign pc_next = (pt_done && pc_q < CW'(NP)) ? pc_q + CW'(1) : pc_q;

  assign issue_last = (k_q == mlast_q) && (i_q == n_last) && (j_q == n_last);
  assign hit = rv_q && !ranked_q[rj_q] && ((col_rdata & ~ranked_q) == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fnds_pkg::ST_LOAD: begin
        if (in_acc && last_in_set_i && pc_next != '0) state_d = fnds_pkg::ST_CMP;
      end
      fnds_pkg::ST_CMP: begin
        if (issue_done_q && !ctl_q.valid) state_d = fnds_pkg::ST_RANK;
      end
      fnds_pkg::ST_RANK: begin
        if (issue_done_q && !rv_q) state_d = fnds_pkg::ST_NEXT;
      end
      fnds_pkg::ST_NEXT: begin
        state_d = (front_q == '0) ? fnds_pkg::ST_EMIT_RD : fnds_pkg::ST_RANK;
      end
      fnds_pkg::ST_EMIT_RD:   state_d = fnds_pkg::ST_EMIT_WAIT;
      fnds_pkg::ST_EMIT_WAIT: state_d = fnds_pkg::ST_EMIT_HOLD;
      fnds_pkg::ST_EMIT_HOLD: begin
        if (!out_stall_i) begin
          state_d = last_result_o ? fnds_pkg::ST_LOAD : fnds_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = fnds_pkg::ST_LOAD;
    endcase
  end

  // outputs and memory strobes
  always_comb begin
    in_stall_o  = (state_q != fnds_pkg::ST_LOAD);
    out_valid_o = (state_q == fnds_pkg::ST_EMIT_HOLD);
    obj_we      = in_acc && (pc_q < CW'(NP));
    obj_waddr   = {pc_q[PW-1:0], oc_q};
    obj_re      = (state_q == fnds_pkg::ST_CMP) && !issue_done_q;
    obj_raddr_a = {i_q, k_q};
    obj_raddr_b = {j_q, k_q};
    col_we      = ctl_q.valid && ctl_q.last && ilast_q;
    col_wdata   = col_q | (NP'(dom) << ti_q);
    col_re      = (state_q == fnds_pkg::ST_RANK) && !issue_done_q;
    rank_we     = hit;
    rank_re     = (state_q == fnds_pkg::ST_EMIT_RD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= fnds_pkg::CFG_W'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= num_objectives_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fnds_pkg::ST_LOAD;
      mlast_q      <= '0;
      pc_q         <= '0;
      oc_q         <= '0;
      ovf_q        <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      issue_done_q <= 1'b0;
      ctl_q        <= '0;
      ilast_q      <= 1'b0;
      ti_q         <= '0;
      tj_q         <= '0;
      col_q        <= '0;
      ranked_q     <= '0;
      front_q      <= '0;
      round_q      <= '0;
      rv_q         <= 1'b0;
      rj_q         <= '0;
      p_q          <= '0;
    end else begin
      state_q <= state_d;
      ctl_q   <= '0;
      rv_q    <= 1'b0;
      case (state_q)
        fnds_pkg::ST_LOAD: begin
          // count the word against the register value of this cycle
          if (in_acc) begin
            oc_q <= pt_done ? '0 : oc_q + OW'(1);
            pc_q <= pc_next;
            if (pt_done && pc_q >= CW'(NP)) ovf_q <= 1'b1;
            if (last_in_set_i) begin
              mlast_q <= mlast_cfg;
              oc_q    <= '0;
              if (pc_next == '0) begin
                ovf_q <= 1'b0;
              end
            end
          end
          i_q          <= '0;
          j_q          <= '0;
          k_q          <= '0;
          issue_done_q <= 1'b0;
          col_q        <= '0;
          ranked_q     <= '0;
          front_q      <= '0;
          round_q      <= RW'(1);
          p_q          <= '0;
        end
        fnds_pkg::ST_CMP: begin
          if (!issue_done_q) begin
            ctl_q.valid <= 1'b1;
            ctl_q.first <= (k_q == '0);
            ctl_q.last  <= (k_q == mlast_q);
            ctl_q.self  <= (i_q == j_q);
            ilast_q     <= (i_q == n_last);
            ti_q        <= i_q;
            tj_q        <= j_q;
            // advance objective, then row, then column
            if (k_q != mlast_q) begin
              k_q <= k_q + OW'(1);
            end else begin
              k_q <= '0;
              if (i_q != n_last) begin
                i_q <= i_q + PW'(1);
              end else begin
                i_q <= '0;
                j_q <= j_q + PW'(1);
              end
            end
            if (issue_last) issue_done_q <= 1'b1;
          end
          if (ctl_q.valid && ctl_q.last) begin
            col_q <= ilast_q ? '0 : col_wdata;
          end
          if (issue_done_q && !ctl_q.valid) begin
            issue_done_q <= 1'b0;
            j_q          <= '0;
          end
        end
        fnds_pkg::ST_RANK: begin
          if (!issue_done_q) begin
            rv_q <= 1'b1;
            rj_q <= j_q;
            j_q  <= j_q + PW'(1);
            if (j_q == n_last) issue_done_q <= 1'b1;
          end
          if (hit) front_q[rj_q] <= 1'b1;
        end
        fnds_pkg::ST_NEXT: begin
          // close the round: this front joins the ranked set
          ranked_q     <= ranked_q | front_q;
          front_q      <= '0;
          round_q      <= round_q + RW'(1);
          j_q          <= '0;
          issue_done_q <= 1'b0;
        end
        fnds_pkg::ST_EMIT_HOLD: begin
          if (!out_stall_i) begin
            p_q <= p_q + PW'(1);
            if (last_result_o) begin
              pc_q  <= '0;
              oc_q  <= '0;
              ovf_q <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output word, loaded once the rank read returns and held while stalled
  always_ff @(posedge clk_i) begin
    if (state_q == fnds_pkg::ST_EMIT_WAIT) begin
      point_index_o <= p_q;
      front_rank_o  <= rank_rdata;
      last_result_o <= (p_q == n_last);
      overflow_o    <= ovf_q;
    end
  end

  fnds_ram #(.WIDTH(fnds_pkg::VAL_W), .DEPTH(fnds_pkg::OBJ_DEPTH)) u_obj_a (
    .clk_i   (clk_i),
    .we_i    (obj_we),
    .waddr_i (obj_waddr),
    .wdata_i (objective_value_i),
    .re_i    (obj_re),
    .raddr_i (obj_raddr_a),
    .rdata_o (obj_a)
  );

  fnds_ram #(.WIDTH(fnds_pkg::VAL_W), .DEPTH(fnds_pkg::OBJ_DEPTH)) u_obj_b (
    .clk_i   (clk_i),
    .we_i    (obj_we),
    .waddr_i (obj_waddr),
    .wdata_i (objective_value_i),
    .re_i    (obj_re),
    .raddr_i (obj_raddr_b),
    .rdata_o (obj_b)
  );

  fnds_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_q),
    .a_i    (obj_a),
    .b_i    (obj_b),
    .dom_o  (dom)
  );

  // column j holds one bit per point that dominates point j
  fnds_ram #(.WIDTH(NP), .DEPTH(NP)) u_col (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (tj_q),
    .wdata_i (col_wdata),
    .re_i    (col_re),
    .raddr_i (j_q),
    .rdata_o (col_rdata)
  );

  fnds_ram #(.WIDTH(RW), .DEPTH(NP)) u_rank (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rj_q),
    .wdata_i (round_q),
    .re_i    (rank_re),
    .raddr_i (p_q),
    .rdata_o (rank_rdata)
  );

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while input open");

  a_rank_wr_in_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rank_we |-> (state_q == fnds_pkg::ST_RANK))
    else $error("rank write outside ranking");

  a_col_wr_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_we |-> (state_q == fnds_pkg::ST_CMP))
    else $error("column write outside compare pass");

  a_front_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fnds_pkg::ST_NEXT) |=> (front_q == '0))
    else $error("front not cleared after round");

endmodule
